// ----- rtl/core/sla_pkg.sv -----
package sla_pkg;

  localparam int unsigned SINE_ENTRIES_DEF = 256;
  localparam int unsigned COLOR_BITS_DEF   = 8;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_MODE  = 2'd1,
    REQ_FLASH = 2'd2
  } req_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF      = 4'd0,
    MODE_BOOT     = 4'd1,
    MODE_LINKING  = 4'd2,
    MODE_LINKED   = 4'd3,
    MODE_UNLINKED = 4'd4,
    MODE_SCAN     = 4'd5,
    MODE_ALARM    = 4'd6,
    MODE_STANDBY  = 4'd7,
    MODE_ERROR    = 4'd8,
    MODE_LEARN    = 4'd9,
    MODE_SETUP    = 4'd10
  } mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LED_ENABLE  = 3'd0,
    REG_PULSE_STEP  = 3'd1,
    REG_BOOT_STEP   = 3'd2,
    REG_FAST_BLINK  = 3'd3,
    REG_SLOW_BLINK  = 3'd4,
    REG_FLASH_LEN   = 3'd5
  } reg_e;

  localparam logic [COLOR_W-1:0] COL_BLACK  = 24'h000000;
  localparam logic [COLOR_W-1:0] COL_BLUE   = 24'h0000FF;
  localparam logic [COLOR_W-1:0] COL_YELLOW = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] COL_GREEN  = 24'h00FF00;
  localparam logic [COLOR_W-1:0] COL_RED    = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COL_ICE    = 24'h5096FF;
  localparam logic [COLOR_W-1:0] COL_AMBER  = 24'hFFBF00;
  localparam logic [COLOR_W-1:0] COL_PURPLE = 24'h800080;
  localparam logic [COLOR_W-1:0] COL_CYAN   = 24'h00FFFF;

  localparam logic [PHASE_W-1:0] PULSE_STEP_RST = 16'd33;
  localparam logic [PHASE_W-1:0] BOOT_STEP_RST  = 16'd66;
  localparam logic [CNT_W-1:0]   FAST_BLINK_RST = 16'd250;
  localparam logic [CNT_W-1:0]   SLOW_BLINK_RST = 16'd1000;
  localparam logic [CNT_W-1:0]   FLASH_LEN_RST  = 16'd100;

endpackage

// ----- rtl/core/sla_fade.sv -----
module sla_fade #(
  parameter int unsigned SINE_ENTRIES = sla_pkg::SINE_ENTRIES_DEF,
  parameter int unsigned COLOR_BITS   = sla_pkg::COLOR_BITS_DEF
) (
  input  logic [sla_pkg::PHASE_W-1:0] phase_i,
  input  logic [sla_pkg::COLOR_W-1:0] color_i,
  output logic [sla_pkg::COLOR_W-1:0] color_o
);
  import sla_pkg::*;

  localparam int unsigned IDX_W = $clog2(SINE_ENTRIES);
  localparam int unsigned NCHAN = COLOR_W / CHAN_W;

  logic [COLOR_BITS:0] sine_lut [SINE_ENTRIES];
  logic [31:0]         idx_prod;
  logic [IDX_W-1:0]    idx;
  logic [COLOR_BITS:0] level;

  // build the sine table at elaboration
  for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_sine
    localparam longint unsigned N    = longint'(SINE_ENTRIES);
    localparam longint unsigned I2   = 2 * longint'(gi);
    localparam bit              FST  = I2 < N;
    localparam longint unsigned A    = FST ? I2 : I2 - N;
    localparam longint unsigned P    = A * (N - A);
    localparam longint unsigned NN5  = 5 * N * N;
    localparam longint unsigned DEN  = 2 * (NN5 - 4 * P);
    localparam longint unsigned NUM  = FST ? NN5 + 12 * P : NN5 - 20 * P;
    localparam longint unsigned LVL  = ((NUM << COLOR_BITS) + DEN / 2) / DEN;
    assign sine_lut[gi] = LVL[COLOR_BITS:0];
  end

  assign idx_prod = 32'(phase_i) * 32'(SINE_ENTRIES);
  assign idx      = idx_prod[PHASE_W +: IDX_W];
  assign level    = sine_lut[idx];

  for (genvar gc = 0; gc < NCHAN; gc++) begin : g_chan
    logic [CHAN_W+COLOR_BITS:0] prod;
    logic [CHAN_W:0]            scaled;
    assign prod   = (CHAN_W+COLOR_BITS+1)'(color_i[gc*CHAN_W +: CHAN_W]) *
                    (CHAN_W+COLOR_BITS+1)'(level);
    assign scaled = prod[COLOR_BITS +: CHAN_W+1];
    assign color_o[gc*CHAN_W +: CHAN_W] = scaled[CHAN_W] ? {CHAN_W{1'b1}} :
                                          scaled[CHAN_W-1:0];
  end

endmodule

// ----- rtl/core/status_led_animator_unit.sv -----
// Status pixel animator. Each input transfer is a millisecond tick, a mode request or an
// activity flash (tuser selects which); each one yields exactly one result transfer carrying
// the pixel color, the shown mode and the flash flag. An item is handled in a single pass from
// the state registers to the output register, so the result appears in the cycle after the input
// transfer and one item is taken every cycle for as long as the output side accepts; the single
// output register is what sets that rate. Tick handling advances the pulse phases and blink
// counters, counts down a flash and, outside one, repaints the pixel (fades via a sine table and
// per-channel multiplies). Registers sit on the APB port at byte address 4*i; writing led_enable
// to 0 blanks the pixel, and while it is 0 items leave the state untouched and report black.
module status_led_animator_unit #(
  parameter int unsigned SINE_ENTRIES = sla_pkg::SINE_ENTRIES_DEF,
  parameter int unsigned COLOR_BITS   = sla_pkg::COLOR_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sla_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // new_state[3:0], flash_color[27:4]
  input  logic [sla_pkg::REQ_W-1:0]      s_axis_tuser,   // req_type[1:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sla_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // pixel_color[23:0], shown_state[27:24],
                                                         // flash_active[28]
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sla_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sla_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sla_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sla_pkg::*;

  logic                 led_enable_q;
  logic [PHASE_W-1:0]   pulse_step_q, boot_step_q;
  logic [CNT_W-1:0]     fast_ms_q, slow_ms_q, flash_len_q;

  logic [MODE_W-1:0]    shown_mode_q, shown_mode_d;
  logic [MODE_W-1:0]    fallback_q, fallback_d;
  logic [CNT_W-1:0]     flash_left_q, flash_left_d;
  logic [COLOR_W-1:0]   pixel_q, pixel_d;
  logic [PHASE_W-1:0]   boot_phase_q, boot_phase_d;
  logic [PHASE_W-1:0]   pulse_phase_q, pulse_phase_d;
  logic [CNT_W-1:0]     fast_count_q, fast_count_d;
  logic [CNT_W-1:0]     slow_count_q, slow_count_d;
  logic                 fast_half_q, fast_half_d;
  logic                 slow_half_q, slow_half_d;
  logic                 blink_shown_q, blink_shown_d;

  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                 in_fire;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [REQ_W-1:0]     req_type;
  logic [MODE_W-1:0]    new_state;
  logic [COLOR_W-1:0]   flash_color;

  logic [CNT_W-1:0]     fast_inc, slow_inc;
  logic [MODE_W-1:0]    render_mode;
  logic [PHASE_W-1:0]   fade_phase;
  logic [COLOR_W-1:0]   fade_in, fade_out;
  logic                 blink_half;
  logic [COLOR_W-1:0]   blink_color;
  logic                 blink_mode;
  logic                 do_render;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign reg_idx       = paddr[APB_ADDR_W-1:2];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign req_type      = s_axis_tuser;
  assign new_state     = s_axis_tdata[MODE_W-1:0];
  assign flash_color   = s_axis_tdata[MODE_W +: COLOR_W];
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    unique case (reg_idx)
      REG_LED_ENABLE: prdata = APB_DATA_W'(led_enable_q);
      REG_PULSE_STEP: prdata = APB_DATA_W'(pulse_step_q);
      REG_BOOT_STEP:  prdata = APB_DATA_W'(boot_step_q);
      REG_FAST_BLINK: prdata = APB_DATA_W'(fast_ms_q);
      REG_SLOW_BLINK: prdata = APB_DATA_W'(slow_ms_q);
      REG_FLASH_LEN:  prdata = APB_DATA_W'(flash_len_q);
      default:        prdata = '0;
    endcase
  end

  // tick counters and phases
  assign boot_phase_d  = boot_phase_q + boot_step_q;
  assign pulse_phase_d = pulse_phase_q + pulse_step_q;
  assign fast_inc      = fast_count_q + CNT_W'(1);
  assign slow_inc      = slow_count_q + CNT_W'(1);
  assign render_mode   = (flash_left_q == CNT_W'(1)) ? fallback_q : shown_mode_q;

  always_comb begin
    fade_phase = pulse_phase_d;
    fade_in    = COL_BLACK;
    unique case (render_mode)
      MODE_BOOT: begin
        fade_phase = boot_phase_d;
        fade_in    = COL_BLUE;
      end
      MODE_SCAN:    fade_in = COL_ICE;
      MODE_ALARM:   fade_in = COL_RED;
      MODE_STANDBY: fade_in = COL_AMBER;
      MODE_SETUP:   fade_in = COL_CYAN;
      default:      fade_in = COL_BLACK;
    endcase
  end

  sla_fade #(
    .SINE_ENTRIES(SINE_ENTRIES),
    .COLOR_BITS  (COLOR_BITS)
  ) u_fade (
    .phase_i(fade_phase),
    .color_i(fade_in),
    .color_o(fade_out)
  );

  always_comb begin
    shown_mode_d  = shown_mode_q;
    fallback_d    = fallback_q;
    flash_left_d  = flash_left_q;
    pixel_d       = pixel_q;
    fast_count_d  = fast_count_q;
    slow_count_d  = slow_count_q;
    fast_half_d   = fast_half_q;
    slow_half_d   = slow_half_q;
    blink_shown_d = blink_shown_q;
    blink_half    = fast_half_q;
    blink_color   = COL_BLACK;
    blink_mode    = 1'b0;
    do_render     = 1'b0;

    if (in_fire && led_enable_q) begin
      unique case (req_type)
        REQ_TICK: begin
          if (fast_inc >= fast_ms_q) begin
            fast_count_d = '0;
            fast_half_d  = !fast_half_q;
          end else begin
            fast_count_d = fast_inc;
          end
          if (slow_inc >= slow_ms_q) begin
            slow_count_d = '0;
            slow_half_d  = !slow_half_q;
          end else begin
            slow_count_d = slow_inc;
          end
          if (flash_left_q != '0) begin
            flash_left_d = flash_left_q - CNT_W'(1);
            if (flash_left_q == CNT_W'(1)) begin
              shown_mode_d = fallback_q;
              do_render    = 1'b1;
            end
          end else begin
            do_render = 1'b1;
          end
        end
        REQ_MODE: begin
          fallback_d = new_state;
          if (flash_left_q == '0 || new_state == MODE_ERROR) begin
            shown_mode_d = new_state;
          end
        end
        REQ_FLASH: begin
          flash_left_d = flash_len_q;
          pixel_d      = flash_color;
        end
        default: begin
        end
      endcase
    end

    if (do_render) begin
      unique case (render_mode)
        MODE_BOOT, MODE_SCAN, MODE_ALARM, MODE_STANDBY, MODE_SETUP: pixel_d = fade_out;
        MODE_LINKED:   pixel_d = COL_GREEN;
        MODE_UNLINKED: pixel_d = COL_RED;
        MODE_LINKING: begin
          blink_mode  = 1'b1;
          blink_half  = fast_half_d;
          blink_color = COL_YELLOW;
        end
        MODE_ERROR: begin
          blink_mode  = 1'b1;
          blink_half  = fast_half_d;
          blink_color = COL_RED;
        end
        MODE_LEARN: begin
          blink_mode  = 1'b1;
          blink_half  = slow_half_d;
          blink_color = COL_PURPLE;
        end
        default: pixel_d = COL_BLACK;
      endcase
      // repaint only on a blink phase change
      if (blink_mode && (!blink_half != blink_shown_q)) begin
        blink_shown_d = !blink_half;
        pixel_d       = blink_half ? COL_BLACK : blink_color;
      end
    end

    if (cfg_wr && reg_idx == REG_LED_ENABLE && !pwdata[0]) begin
      pixel_d = COL_BLACK;
    end
  end

  always_comb begin
    out_data_d = '0;
    out_data_d[COLOR_W-1:0]          = led_enable_q ? pixel_d : COL_BLACK;
    out_data_d[COLOR_W +: MODE_W]    = shown_mode_d;
    out_data_d[COLOR_W + MODE_W]     = (flash_left_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_enable_q  <= 1'b1;
      pulse_step_q  <= PULSE_STEP_RST;
      boot_step_q   <= BOOT_STEP_RST;
      fast_ms_q     <= FAST_BLINK_RST;
      slow_ms_q     <= SLOW_BLINK_RST;
      flash_len_q   <= FLASH_LEN_RST;
      shown_mode_q  <= MODE_OFF;
      fallback_q    <= MODE_OFF;
      flash_left_q  <= '0;
      pixel_q       <= COL_BLACK;
      boot_phase_q  <= '0;
      pulse_phase_q <= '0;
      fast_count_q  <= '0;
      slow_count_q  <= '0;
      fast_half_q   <= 1'b0;
      slow_half_q   <= 1'b0;
      blink_shown_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_LED_ENABLE: led_enable_q <= pwdata[0];
          REG_PULSE_STEP: pulse_step_q <= pwdata[PHASE_W-1:0];
          REG_BOOT_STEP:  boot_step_q  <= pwdata[PHASE_W-1:0];
          REG_FAST_BLINK: fast_ms_q    <= pwdata[CNT_W-1:0];
          REG_SLOW_BLINK: slow_ms_q    <= pwdata[CNT_W-1:0];
          REG_FLASH_LEN:  flash_len_q  <= pwdata[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      shown_mode_q  <= shown_mode_d;
      fallback_q    <= fallback_d;
      flash_left_q  <= flash_left_d;
      pixel_q       <= pixel_d;
      fast_count_q  <= fast_count_d;
      slow_count_q  <= slow_count_d;
      fast_half_q   <= fast_half_d;
      slow_half_q   <= slow_half_d;
      blink_shown_q <= blink_shown_d;
      if (in_fire && led_enable_q && req_type == REQ_TICK) begin
        boot_phase_q  <= boot_phase_d;
        pulse_phase_q <= pulse_phase_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_flash_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && led_enable_q && req_type == REQ_TICK && flash_left_q != '0
    |=> flash_left_q == $past(flash_left_q) - CNT_W'(1))
    else $error("flash countdown skipped");

  a_disabled_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !led_enable_q
    |=> $stable(shown_mode_q) && $stable(flash_left_q) && $stable(pulse_phase_q))
    else $error("state changed while disabled");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && req_type == REQ_TICK) |=> $stable(boot_phase_q) && $stable(fast_count_q))
    else $error("tick state moved without a tick");
`endif

endmodule
